// File: src/ppcc_pkg.sv
package ppcc_pkg;

    typedef logic [7:0] t_byte;

    // Conversion selected by the mode register.
    typedef enum logic [2:0] {
        MODE_UYVY_BGR,
        MODE_YUY2_BGR,
        MODE_Y800_BGR,
        MODE_RGB_BGR,
        MODE_RGB_UYVY,
        MODE_BGR_UYVY,
        MODE_Y800_UYVY,
        MODE_YUV444_UYVY
    } t_mode;

    typedef struct packed {
        t_byte in_byte0;
        t_byte in_byte1;
        t_byte in_byte2;
        t_byte in_byte3;
        t_byte in_byte4;
        t_byte in_byte5;
    } t_in_item;

    typedef struct packed {
        t_byte      out_byte0;
        t_byte      out_byte1;
        t_byte      out_byte2;
        t_byte      out_byte3;
        t_byte      out_byte4;
        t_byte      out_byte5;
        logic [2:0] out_count;
    } t_out_item;

    localparam logic [2:0] COUNT_BGR  = 3'd6;
    localparam logic [2:0] COUNT_UYVY = 3'd4;
    localparam t_byte      CHROMA_MID = 8'h80;

    // Matrix operands of one pixel. For a YCbCr source a, b, c are
    // Y-16, Cb-128 and Cr-128; for an RGB source they are R, G and B.
    typedef struct packed {
        logic              rgb_src;
        logic signed [8:0] a;
        logic signed [8:0] b;
        logic signed [8:0] c;
    } t_operands;

    typedef t_operands [1:0] t_lane_ops;

    // Three 8-bit channels of one pixel: B, G, R or Y, U, V.
    typedef t_byte [2:0] t_chans;

    // Sideband that travels beside the arithmetic pipeline.
    typedef struct packed {
        logic     valid;
        t_mode    mode;
        t_in_item raw;
    } t_ctl;

    typedef logic signed [14:0] t_coef;
    typedef logic signed [23:0] t_prod;
    typedef logic signed [25:0] t_sum;
    typedef logic signed [13:0] t_quot;
    typedef logic signed [14:0] t_level;

    localparam int FRAC_BITS = 12;

    // BT.601 studio-range coefficients, 12 fractional bits.
    localparam t_coef CY  = 15'sd4768;
    localparam t_coef CRV = 15'sd6537;
    localparam t_coef CGV = 15'sd3330;
    localparam t_coef CGU = 15'sd1602;
    localparam t_coef CBU = 15'sd8266;
    localparam t_coef KYR = 15'sd1053;
    localparam t_coef KYG = 15'sd2064;
    localparam t_coef KYB = 15'sd401;
    localparam t_coef KUR = 15'sd606;
    localparam t_coef KUG = 15'sd1192;
    localparam t_coef KUB = 15'sd1798;
    localparam t_coef KVR = 15'sd1798;
    localparam t_coef KVG = 15'sd1507;
    localparam t_coef KVB = 15'sd291;
    localparam t_coef CZERO = 15'sd0;

    // Indexed by [rgb_src][output channel][operand].
    localparam t_coef COEF [2][3][3] = '{
        '{ '{CY,  CBU,   CZERO},
           '{CY,  -CGU,  -CGV},
           '{CY,  CZERO, CRV} },
        '{ '{KYR,  KYG,  KYB},
           '{-KUR, -KUG, KUB},
           '{KVR,  -KVG, -KVB} }
    };

    // Offset added after truncation, indexed by [rgb_src][output channel].
    localparam t_level OFFSET [2][3] = '{
        '{15'sd0,  15'sd0,   15'sd0},
        '{15'sd16, 15'sd128, 15'sd128}
    };

    function automatic t_operands ycc_ops(input t_byte y, input t_byte cb, input t_byte cr);
        t_operands ops;
        ops.rgb_src = 1'b0;
        ops.a = $signed({1'b0, y}) - 9'sd16;
        ops.b = $signed({1'b0, cb}) - 9'sd128;
        ops.c = $signed({1'b0, cr}) - 9'sd128;
        return ops;
    endfunction

    function automatic t_operands rgb_ops(input t_byte r, input t_byte g, input t_byte b);
        t_operands ops;
        ops.rgb_src = 1'b1;
        ops.a = $signed({1'b0, r});
        ops.b = $signed({1'b0, g});
        ops.c = $signed({1'b0, b});
        return ops;
    endfunction

endpackage

// File: src/ppcc_operand_sel.sv
module ppcc_operand_sel (
    input  logic               i_clk,
    input  ppcc_pkg::t_in_item i_pixels,
    input  ppcc_pkg::t_mode    i_mode,
    output ppcc_pkg::t_lane_ops o_ops
);
    import ppcc_pkg::*;

    t_lane_ops n_ops;
    t_lane_ops r_ops;

    // Picks each pixel's matrix operands out of the source byte order.
    always_comb begin
        n_ops = '0;
        case (i_mode)
            MODE_UYVY_BGR: begin
                n_ops[0] = ycc_ops(i_pixels.in_byte1, i_pixels.in_byte0, i_pixels.in_byte2);
                n_ops[1] = ycc_ops(i_pixels.in_byte3, i_pixels.in_byte0, i_pixels.in_byte2);
            end
            MODE_YUY2_BGR: begin
                n_ops[0] = ycc_ops(i_pixels.in_byte0, i_pixels.in_byte1, i_pixels.in_byte3);
                n_ops[1] = ycc_ops(i_pixels.in_byte2, i_pixels.in_byte1, i_pixels.in_byte3);
            end
            MODE_Y800_BGR: begin
                n_ops[0] = ycc_ops(i_pixels.in_byte0, CHROMA_MID, CHROMA_MID);
                n_ops[1] = ycc_ops(i_pixels.in_byte1, CHROMA_MID, CHROMA_MID);
            end
            MODE_RGB_UYVY: begin
                n_ops[0] = rgb_ops(i_pixels.in_byte0, i_pixels.in_byte1, i_pixels.in_byte2);
                n_ops[1] = rgb_ops(i_pixels.in_byte3, i_pixels.in_byte4, i_pixels.in_byte5);
            end
            MODE_BGR_UYVY: begin
                n_ops[0] = rgb_ops(i_pixels.in_byte2, i_pixels.in_byte1, i_pixels.in_byte0);
                n_ops[1] = rgb_ops(i_pixels.in_byte5, i_pixels.in_byte4, i_pixels.in_byte3);
            end
            default: begin
                n_ops = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ops <= n_ops;
    end

    assign o_ops = r_ops;

endmodule

// File: src/ppcc_matrix.sv
module ppcc_matrix (
    input  logic                i_clk,
    input  ppcc_pkg::t_operands i_ops,
    output ppcc_pkg::t_chans    o_chan
);
    import ppcc_pkg::*;

    logic signed [8:0] opnd [3];
    t_prod             r_prod [3][3];
    logic              r_rgb_p;
    t_sum              r_sum [3];
    logic              r_rgb_s;
    t_chans            r_chan;
    t_sum              adj [3];
    t_quot             quot [3];
    t_level            level [3];
    t_chans            n_chan;

    assign opnd[0] = i_ops.a;
    assign opnd[1] = i_ops.b;
    assign opnd[2] = i_ops.c;

    // Products: one constant-coefficient multiply per matrix entry.
    always_ff @(posedge i_clk) begin
        r_rgb_p <= i_ops.rgb_src;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[r][k] <= t_prod'(COEF[i_ops.rgb_src][r][k]) * t_prod'(opnd[k]);
            end
        end
    end

    // Row sums.
    always_ff @(posedge i_clk) begin
        r_rgb_s <= r_rgb_p;
        for (int r = 0; r < 3; r++) begin
            r_sum[r] <= t_sum'(r_prod[r][0]) + t_sum'(r_prod[r][1]) + t_sum'(r_prod[r][2]);
        end
    end

    // Truncation toward zero, offset and saturation to 0..255.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            adj[r]   = r_sum[r] + (r_sum[r][25] ? t_sum'((1 << FRAC_BITS) - 1) : t_sum'(0));
            quot[r]  = t_quot'(adj[r] >>> FRAC_BITS);
            level[r] = t_level'(quot[r]) + OFFSET[r_rgb_s][r];
            if (level[r] < 15'sd0) begin
                n_chan[r] = 8'd0;
            end else if (level[r] > 15'sd255) begin
                n_chan[r] = 8'd255;
            end else begin
                n_chan[r] = level[r][7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chan <= n_chan;
    end

    assign o_chan = r_chan;

endmodule

// File: src/ppcc_format.sv
module ppcc_format (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ppcc_pkg::t_ctl      i_ctl,
    input  ppcc_pkg::t_chans    i_lane0,
    input  ppcc_pkg::t_chans    i_lane1,
    output logic                o_strobe,
    output ppcc_pkg::t_out_item o_result
);
    import ppcc_pkg::*;

    logic [8:0] sum_u;
    logic [8:0] sum_v;
    logic [8:0] sum_cb;
    logic [8:0] sum_cr;
    t_out_item  n_result;
    t_out_item  r_result;
    logic       r_strobe;

    assign sum_u  = {1'b0, i_lane0[1]} + {1'b0, i_lane1[1]};
    assign sum_v  = {1'b0, i_lane0[2]} + {1'b0, i_lane1[2]};
    assign sum_cb = {1'b0, i_ctl.raw.in_byte1} + {1'b0, i_ctl.raw.in_byte4};
    assign sum_cr = {1'b0, i_ctl.raw.in_byte2} + {1'b0, i_ctl.raw.in_byte5};

    // Lays the channels out in destination byte order.
    always_comb begin
        n_result = '0;
        n_result.out_count = COUNT_UYVY;
        case (i_ctl.mode)
            MODE_UYVY_BGR, MODE_YUY2_BGR, MODE_Y800_BGR: begin
                n_result.out_byte0 = i_lane0[0];
                n_result.out_byte1 = i_lane0[1];
                n_result.out_byte2 = i_lane0[2];
                n_result.out_byte3 = i_lane1[0];
                n_result.out_byte4 = i_lane1[1];
                n_result.out_byte5 = i_lane1[2];
                n_result.out_count = COUNT_BGR;
            end
            MODE_RGB_BGR: begin
                n_result.out_byte0 = i_ctl.raw.in_byte2;
                n_result.out_byte1 = i_ctl.raw.in_byte1;
                n_result.out_byte2 = i_ctl.raw.in_byte0;
                n_result.out_byte3 = i_ctl.raw.in_byte5;
                n_result.out_byte4 = i_ctl.raw.in_byte4;
                n_result.out_byte5 = i_ctl.raw.in_byte3;
                n_result.out_count = COUNT_BGR;
            end
            MODE_RGB_UYVY, MODE_BGR_UYVY: begin
                n_result.out_byte0 = sum_u[8:1];
                n_result.out_byte1 = i_lane0[0];
                n_result.out_byte2 = sum_v[8:1];
                n_result.out_byte3 = i_lane1[0];
            end
            MODE_Y800_UYVY: begin
                n_result.out_byte0 = CHROMA_MID;
                n_result.out_byte1 = i_ctl.raw.in_byte0;
                n_result.out_byte2 = CHROMA_MID;
                n_result.out_byte3 = i_ctl.raw.in_byte1;
            end
            default: begin
                n_result.out_byte0 = sum_cb[8:1];
                n_result.out_byte1 = i_ctl.raw.in_byte0;
                n_result.out_byte2 = sum_cr[8:1];
                n_result.out_byte3 = i_ctl.raw.in_byte3;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// File: src/packed_pixel_color_converter.sv
// Packed pixel color converter. Each transfer on the input side carries one
// two-pixel group in a packed source format; the mode register picks one of
// eight conversions to packed BGR or packed UYVY. Those that change color
// space use the BT.601 studio-range matrices with 12 fractional bits,
// truncation toward zero and saturation to 0..255. The block takes a new group
// in every clock cycle: busy is always low, so start alone launches a transfer.
// The result leaves on o_result for exactly one cycle with o_strobe high. The
// receiver cannot hold results off, and none is needed, because the pipeline
// never stalls. The pipeline stages are operand selection, the coefficient
// multiplies, the row sums, truncation with saturation, and byte ordering
// with the chroma average.
// Write the mode only while no group is in flight; the write channel is
// always ready and the new mode applies to groups started after it.
module packed_pixel_color_converter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ppcc_pkg::t_in_item  i_pixels,
    output logic                o_strobe,
    output ppcc_pkg::t_out_item o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_data
);
    import ppcc_pkg::*;

    localparam int CTL_DEPTH = 4;

    t_mode     r_mode;
    t_ctl      n_ctl;
    t_ctl      r_ctl [CTL_DEPTH];
    t_lane_ops lane_ops;
    t_chans    lane_chan [2];

    // The pipeline never stalls, so the block is never busy and a
    // configuration transfer is always taken.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_UYVY_BGR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= t_mode'(i_cfg_data);
        end
    end

    // The mode and raw bytes ride along with each group, so the output
    // stage sees the mode the group was started under.
    always_comb begin
        n_ctl.valid = start && !busy;
        n_ctl.mode  = r_mode;
        n_ctl.raw   = i_pixels;
    end

    // The whole sideband pipe is cleared on reset, so no stale valid bit
    // can produce a result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < CTL_DEPTH; s++) begin
                r_ctl[s] <= '0;
            end
        end else begin
            r_ctl[0] <= n_ctl;
            for (int s = 1; s < CTL_DEPTH; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    ppcc_operand_sel u_operand_sel (
        .i_clk    (i_clk),
        .i_pixels (i_pixels),
        .i_mode   (r_mode),
        .o_ops    (lane_ops)
    );

    // One matrix lane per pixel of the group.
    for (genvar g = 0; g < 2; g++) begin : g_lane
        ppcc_matrix u_matrix (
            .i_clk  (i_clk),
            .i_ops  (lane_ops[g]),
            .o_chan (lane_chan[g])
        );
    end

    ppcc_format u_format (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_ctl[CTL_DEPTH-1]),
        .i_lane0  (lane_chan[0]),
        .i_lane1  (lane_chan[1]),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
